// ===== design/twad_pkg.sv =====
// ----------------------------------------------------------------------------
// twad_pkg: shared types and constants for the traffic anomaly detector
// Field widths, store sizes, register indexes, reset values and the
// controller to datapath command and status groups.
// ----------------------------------------------------------------------------
package twad_pkg;

  // store sizes
  localparam int IP_SLOTS    = 32;
  localparam int PORT_SLOTS  = 32;
  localparam int IP_IDX_W    = $clog2(IP_SLOTS);
  localparam int IP_FILL_W   = $clog2(IP_SLOTS + 1);
  localparam int PORT_IDX_W  = $clog2(PORT_SLOTS);
  localparam int PORT_FILL_W = $clog2(PORT_SLOTS + 1);

  // field widths
  localparam int TS_W      = 64;
  localparam int IP_W      = 32;
  localparam int PORT_W    = 16;
  localparam int PROTO_W   = 8;
  localparam int FLAGS_W   = 8;
  localparam int CNT_W     = 32;
  localparam int TOT_W     = 6;
  localparam int WLEN_W    = 40;
  localparam int LIM_W     = 5;
  localparam int RATIO_W   = 8;
  localparam int PROD_W    = RATIO_W + CNT_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  // reported totals stop at the largest code the total port can carry
  localparam int TOT_MAX      = (2 ** TOT_W) - 1;
  localparam int IP_TOT_CAP   = (IP_SLOTS > TOT_MAX) ? TOT_MAX : IP_SLOTS;
  localparam int PORT_TOT_CAP = (PORT_SLOTS > TOT_MAX) ? TOT_MAX : PORT_SLOTS;

  // packet classification
  localparam logic [PORT_W-1:0]  SMB_PORT_A  = 16'd445;
  localparam logic [PORT_W-1:0]  SMB_PORT_B  = 16'd139;
  localparam logic [PROTO_W-1:0] PROTO_TCP   = 8'd6;
  localparam int                 RST_BIT_POS = 2;
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

  // item kinds
  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_STALE  = 1'b1;

  // register reset values
  localparam logic [WLEN_W-1:0]  WLEN_RST       = 40'd10000000000;
  localparam logic [LIM_W-1:0]   EXT_LIMIT_RST  = 5'd10;
  localparam logic [CNT_W-1:0]   SMB_LIMIT_RST  = 32'd5;
  localparam logic [LIM_W-1:0]   PORT_LIMIT_RST = 5'd20;
  localparam logic [RATIO_W-1:0] RATIO_RST      = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 3'd0,
    CFG_EXT_IP_LIMIT  = 3'd1,
    CFG_SMB_LIMIT     = 3'd2,
    CFG_PORT_LIMIT    = 3'd3,
    CFG_RST_RATIO     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic capture;  // take the input beat into the item registers
    logic expire;   // window start and expiry test
    logic update;   // store lookups and counters
    logic mul;      // ratio product
    logic load;     // result into the output register
  } twad_cmd_t;

  typedef struct packed {
    logic is_packet;
  } twad_status_t;

endpackage

// ===== design/twad_ctrl.sv =====
// ----------------------------------------------------------------------------
// twad_ctrl: item sequencer
// Walks one item through expiry, update (packets only), product and result,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module twad_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  twad_pkg::twad_status_t status,
  output twad_pkg::twad_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXPIRE = 5'b00010,
    S_UPDATE = 5'b00100,
    S_MUL    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.capture = in_valid && (state_r == S_IDLE);
    cmd.expire  = (state_r == S_EXPIRE);
    cmd.update  = (state_r == S_UPDATE);
    cmd.mul     = (state_r == S_MUL);
    cmd.load    = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXPIRE;
      end
      S_EXPIRE: begin
        // stale checks skip the store update
        state_nxt = status.is_packet ? S_UPDATE : S_MUL;
      end
      S_UPDATE: state_nxt = S_MUL;
      S_MUL:    state_nxt = S_DONE;
      S_DONE: begin
        if (cmd.load) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/twad_datapath.sv =====
// ----------------------------------------------------------------------------
// twad_datapath: window state, stores, counters and result register
// Holds the configuration registers, the two lookup stores, the window
// counters and the ratio product; acts on the sequencer's commands.
// ----------------------------------------------------------------------------
module twad_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  twad_pkg::twad_cmd_t                  cmd,
  output twad_pkg::twad_status_t               status,
  // configuration
  input  logic                                 cfg_we,
  input  logic [twad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twad_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input item
  input  logic                                 in_kind,
  input  logic [twad_pkg::TS_W-1:0]            in_timestamp,
  input  logic [twad_pkg::IP_W-1:0]            in_dst_ip,
  input  logic                                 in_dst_external,
  input  logic [twad_pkg::PORT_W-1:0]          in_dst_port,
  input  logic [twad_pkg::PROTO_W-1:0]         in_protocol,
  input  logic [twad_pkg::FLAGS_W-1:0]         in_tcp_flags,
  // result item
  output logic                                 out_suspicious,
  output logic [twad_pkg::TOT_W-1:0]           out_external_ip_total,
  output logic [twad_pkg::CNT_W-1:0]           out_smb_total,
  output logic [twad_pkg::CNT_W-1:0]           out_rst_total,
  output logic [twad_pkg::CNT_W-1:0]           out_tcp_total,
  output logic [twad_pkg::TOT_W-1:0]           out_port_total,
  output logic [twad_pkg::TS_W-1:0]            out_window_begin,
  output logic                                 out_store_overflow
);

  // configuration registers
  logic [twad_pkg::WLEN_W-1:0]  wlen_r;
  logic [twad_pkg::LIM_W-1:0]   ext_limit_r;
  logic [twad_pkg::CNT_W-1:0]   smb_limit_r;
  logic [twad_pkg::LIM_W-1:0]   port_limit_r;
  logic [twad_pkg::RATIO_W-1:0] ratio_r;

  // captured item
  logic                          kind_r;
  logic [twad_pkg::TS_W-1:0]     ts_r;
  logic [twad_pkg::IP_W-1:0]     ip_r;
  logic                          ext_r;
  logic [twad_pkg::PORT_W-1:0]   port_r;
  logic [twad_pkg::PROTO_W-1:0]  proto_r;
  logic [twad_pkg::FLAGS_W-1:0]  flags_r;

  // window state
  logic [twad_pkg::TS_W-1:0]        origin_r, origin_nxt;
  logic [twad_pkg::IP_FILL_W-1:0]   ip_fill_r, ip_fill_nxt;
  logic [twad_pkg::PORT_FILL_W-1:0] port_fill_r, port_fill_nxt;
  logic [twad_pkg::CNT_W-1:0]       smb_cnt_r, smb_cnt_nxt;
  logic [twad_pkg::CNT_W-1:0]       rst_cnt_r, rst_cnt_nxt;
  logic [twad_pkg::CNT_W-1:0]       tcp_cnt_r, tcp_cnt_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [twad_pkg::IP_W-1:0]        ip_store_r   [twad_pkg::IP_SLOTS];
  logic [twad_pkg::PORT_W-1:0]      port_store_r [twad_pkg::PORT_SLOTS];
  logic [twad_pkg::PROD_W-1:0]      prod_r;

  // expiry
  logic [twad_pkg::TS_W-1:0] origin_eff, elapsed;
  logic                      expired;

  // lookups
  logic [twad_pkg::IP_SLOTS-1:0]   ip_match;
  logic [twad_pkg::PORT_SLOTS-1:0] port_match;
  logic ip_hit, port_hit, ip_full, port_full;
  logic ip_add, port_add, is_tcp, is_smb, is_rst, port_valid;

  logic suspicious;

  assign status.is_packet = (kind_r == twad_pkg::KIND_PACKET);

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r       <= twad_pkg::WLEN_RST;
      ext_limit_r  <= twad_pkg::EXT_LIMIT_RST;
      smb_limit_r  <= twad_pkg::SMB_LIMIT_RST;
      port_limit_r <= twad_pkg::PORT_LIMIT_RST;
      ratio_r      <= twad_pkg::RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        twad_pkg::CFG_WINDOW_LENGTH: wlen_r       <= cfg_data[twad_pkg::WLEN_W-1:0];
        twad_pkg::CFG_EXT_IP_LIMIT:  ext_limit_r  <= cfg_data[twad_pkg::LIM_W-1:0];
        twad_pkg::CFG_SMB_LIMIT:     smb_limit_r  <= cfg_data[twad_pkg::CNT_W-1:0];
        twad_pkg::CFG_PORT_LIMIT:    port_limit_r <= cfg_data[twad_pkg::LIM_W-1:0];
        twad_pkg::CFG_RST_RATIO:     ratio_r      <= cfg_data[twad_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      ts_r    <= in_timestamp;
      ip_r    <= in_dst_ip;
      ext_r   <= in_dst_external;
      port_r  <= in_dst_port;
      proto_r <= in_protocol;
      flags_r <= in_tcp_flags;
    end
  end

  // zero origin marks no open window; a packet or an expiry opens one
  always_comb begin
    origin_eff = origin_r;
    if (kind_r == twad_pkg::KIND_PACKET && origin_r == '0) origin_eff = ts_r;
    elapsed = ts_r - origin_eff;
    expired = elapsed > {{(twad_pkg::TS_W - twad_pkg::WLEN_W){1'b0}}, wlen_r};
  end

  always_comb begin
    for (int i = 0; i < twad_pkg::IP_SLOTS; i++) begin
      ip_match[i] = (ip_store_r[i] == ip_r) &&
                    (twad_pkg::IP_FILL_W'(i) < ip_fill_r);
    end
    for (int j = 0; j < twad_pkg::PORT_SLOTS; j++) begin
      port_match[j] = (port_store_r[j] == port_r) &&
                      (twad_pkg::PORT_FILL_W'(j) < port_fill_r);
    end
    ip_hit     = |ip_match;
    port_hit   = |port_match;
    ip_full    = (ip_fill_r == twad_pkg::IP_FILL_W'(twad_pkg::IP_SLOTS));
    port_full  = (port_fill_r == twad_pkg::PORT_FILL_W'(twad_pkg::PORT_SLOTS));
    port_valid = (port_r != '0);
    ip_add     = ext_r && !ip_hit && !ip_full;
    port_add   = port_valid && !port_hit && !port_full;
    is_tcp     = (proto_r == twad_pkg::PROTO_TCP);
    is_smb     = (port_r == twad_pkg::SMB_PORT_A) || (port_r == twad_pkg::SMB_PORT_B);
    is_rst     = is_tcp && flags_r[twad_pkg::RST_BIT_POS];
  end

  always_comb begin
    origin_nxt    = origin_r;
    ip_fill_nxt   = ip_fill_r;
    port_fill_nxt = port_fill_r;
    smb_cnt_nxt   = smb_cnt_r;
    rst_cnt_nxt   = rst_cnt_r;
    tcp_cnt_nxt   = tcp_cnt_r;
    ovf_nxt       = ovf_r;
    if (cmd.expire) begin
      if (expired) begin
        origin_nxt    = ts_r;
        ip_fill_nxt   = '0;
        port_fill_nxt = '0;
        smb_cnt_nxt   = '0;
        rst_cnt_nxt   = '0;
        tcp_cnt_nxt   = '0;
        ovf_nxt       = 1'b0;
      end else begin
        origin_nxt = origin_eff;
      end
    end else if (cmd.update) begin
      if (ip_add) ip_fill_nxt = ip_fill_r + 1'b1;
      if (port_add) port_fill_nxt = port_fill_r + 1'b1;
      if ((ext_r && !ip_hit && ip_full) || (port_valid && !port_hit && port_full)) begin
        ovf_nxt = 1'b1;
      end
      if (is_smb && smb_cnt_r != twad_pkg::CNT_MAX) smb_cnt_nxt = smb_cnt_r + 1'b1;
      if (is_tcp && tcp_cnt_r != twad_pkg::CNT_MAX) tcp_cnt_nxt = tcp_cnt_r + 1'b1;
      if (is_rst && rst_cnt_r != twad_pkg::CNT_MAX) rst_cnt_nxt = rst_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r    <= '0;
      ip_fill_r   <= '0;
      port_fill_r <= '0;
      smb_cnt_r   <= '0;
      rst_cnt_r   <= '0;
      tcp_cnt_r   <= '0;
      ovf_r       <= 1'b0;
    end else begin
      origin_r    <= origin_nxt;
      ip_fill_r   <= ip_fill_nxt;
      port_fill_r <= port_fill_nxt;
      smb_cnt_r   <= smb_cnt_nxt;
      rst_cnt_r   <= rst_cnt_nxt;
      tcp_cnt_r   <= tcp_cnt_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // store writes land at the fill position
  always_ff @(posedge clk) begin
    if (cmd.update && ip_add) begin
      ip_store_r[ip_fill_r[twad_pkg::IP_IDX_W-1:0]] <= ip_r;
    end
    if (cmd.update && port_add) begin
      port_store_r[port_fill_r[twad_pkg::PORT_IDX_W-1:0]] <= port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= {{twad_pkg::CNT_W{1'b0}}, ratio_r} * {{twad_pkg::RATIO_W{1'b0}}, tcp_cnt_r};
    end
  end

  always_comb begin
    suspicious = (32'(ip_fill_r) > 32'(ext_limit_r)) ||
                 (smb_cnt_r > smb_limit_r) ||
                 (32'(port_fill_r) > 32'(port_limit_r)) ||
                 ((tcp_cnt_r != '0) &&
                  ({rst_cnt_r, {twad_pkg::RATIO_W{1'b0}}} > prod_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_suspicious        <= suspicious;
      out_external_ip_total <= (32'(ip_fill_r) > 32'(twad_pkg::TOT_MAX)) ?
                               twad_pkg::TOT_W'(twad_pkg::TOT_MAX) :
                               twad_pkg::TOT_W'(ip_fill_r);
      out_port_total        <= (32'(port_fill_r) > 32'(twad_pkg::TOT_MAX)) ?
                               twad_pkg::TOT_W'(twad_pkg::TOT_MAX) :
                               twad_pkg::TOT_W'(port_fill_r);
      out_smb_total         <= smb_cnt_r;
      out_rst_total         <= rst_cnt_r;
      out_tcp_total         <= tcp_cnt_r;
      out_window_begin      <= origin_r;
      out_store_overflow    <= ovf_r;
    end
  end

endmodule

// ===== design/windowed_traffic_anomaly_detector_top.sv =====
// ----------------------------------------------------------------------------
// windowed_traffic_anomaly_detector_top: windowed traffic anomaly detector
// Counts distinct external IPs, distinct ports, SMB, TCP and RST packets in
// a time window and flags suspicious traffic after every beat.
// ----------------------------------------------------------------------------
// Each input beat (packet event or stale check) yields exactly one result
// beat. The beat is captured at its acceptance edge, then worked through the
// window expiry test (64-bit subtract and compare), store lookup and counter
// update (parallel compare across both stores; skipped for a stale check),
// ratio product (8x32 multiply), then threshold tests into the output
// register. in_ready is high only while the sequencer is idle, so one item is
// worked at a time and a new beat is taken only once the last item's result
// is loaded; a result that waits in the output register holds the next item
// in its last step. The output register lets the
// next item enter while a finished result still waits. No clearing pass is
// needed after reset: the stores are tracked by fill counts. cfg_ready is
// always high; registers should be written only while no item is in flight.
// ----------------------------------------------------------------------------
module windowed_traffic_anomaly_detector_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [twad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [twad_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input beats
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [twad_pkg::TS_W-1:0]            in_timestamp,
  input  logic [twad_pkg::IP_W-1:0]            in_dst_ip,
  input  logic                                 in_dst_external,
  input  logic [twad_pkg::PORT_W-1:0]          in_dst_port,
  input  logic [twad_pkg::PROTO_W-1:0]         in_protocol,
  input  logic [twad_pkg::FLAGS_W-1:0]         in_tcp_flags,
  // result beats
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_suspicious,
  output logic [twad_pkg::TOT_W-1:0]           out_external_ip_total,
  output logic [twad_pkg::CNT_W-1:0]           out_smb_total,
  output logic [twad_pkg::CNT_W-1:0]           out_rst_total,
  output logic [twad_pkg::CNT_W-1:0]           out_tcp_total,
  output logic [twad_pkg::TOT_W-1:0]           out_port_total,
  output logic [twad_pkg::TS_W-1:0]            out_window_begin,
  output logic                                 out_store_overflow
);

  twad_pkg::twad_cmd_t    cmd;
  twad_pkg::twad_status_t status;

  // register writes complete in the cycle they are offered
  assign cfg_ready = 1'b1;

  twad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  twad_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_we                (cfg_valid && cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_kind               (in_kind),
    .in_timestamp          (in_timestamp),
    .in_dst_ip             (in_dst_ip),
    .in_dst_external       (in_dst_external),
    .in_dst_port           (in_dst_port),
    .in_protocol           (in_protocol),
    .in_tcp_flags          (in_tcp_flags),
    .out_suspicious        (out_suspicious),
    .out_external_ip_total (out_external_ip_total),
    .out_smb_total         (out_smb_total),
    .out_rst_total         (out_rst_total),
    .out_tcp_total         (out_tcp_total),
    .out_port_total        (out_port_total),
    .out_window_begin      (out_window_begin),
    .out_store_overflow    (out_store_overflow)
  );

endmodule

// ===== design/twad_checker.sv =====
// ----------------------------------------------------------------------------
// twad_checker: port-level checks for the traffic anomaly detector
// Watches the top level's ports; attached by bind.
// ----------------------------------------------------------------------------
module twad_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [twad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [twad_pkg::CFG_DATA_W-1:0]      cfg_data,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 in_kind,
  input logic [twad_pkg::TS_W-1:0]            in_timestamp,
  input logic [twad_pkg::IP_W-1:0]            in_dst_ip,
  input logic                                 in_dst_external,
  input logic [twad_pkg::PORT_W-1:0]          in_dst_port,
  input logic [twad_pkg::PROTO_W-1:0]         in_protocol,
  input logic [twad_pkg::FLAGS_W-1:0]         in_tcp_flags,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_suspicious,
  input logic [twad_pkg::TOT_W-1:0]           out_external_ip_total,
  input logic [twad_pkg::CNT_W-1:0]           out_smb_total,
  input logic [twad_pkg::CNT_W-1:0]           out_rst_total,
  input logic [twad_pkg::CNT_W-1:0]           out_tcp_total,
  input logic [twad_pkg::TOT_W-1:0]           out_port_total,
  input logic [twad_pkg::TS_W-1:0]            out_window_begin,
  input logic                                 out_store_overflow
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tcp_total) &&
                                $stable(out_window_begin))
    else $error("result changed while stalled");

  // one item in flight: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // RSTs are counted only on TCP packets
  a_rst_le_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rst_total <= out_tcp_total)
    else $error("RST count above TCP count");

  // overflow only with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_overflow |->
      (out_external_ip_total == twad_pkg::TOT_W'(twad_pkg::IP_TOT_CAP)) ||
      (out_port_total == twad_pkg::TOT_W'(twad_pkg::PORT_TOT_CAP)))
    else $error("overflow flagged with no full store");

endmodule

bind windowed_traffic_anomaly_detector_top twad_checker u_twad_checker (.*);
